>>> rtl/efb_pkg.sv
`default_nettype none

package efb_pkg;

   // Frame layout.
   localparam int unsigned HDR_BYTES   = 14;
   localparam int unsigned FCS_BYTES   = 4;
   localparam int unsigned CNT_W       = 4;
   localparam int unsigned MAC_W       = 48;
   localparam int unsigned TYPE_W      = 16;
   localparam int unsigned CSR_DATA_W  = 48;
   localparam int unsigned CSR_INDEX_W = 2;

   // Request queue between front and back.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Reflected CRC-32.
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   // Register indexes and reset values.
   localparam logic [CSR_INDEX_W-1:0] CSR_DEST_MAC   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_MAC    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ETHER_TYPE = 2'd2;

   localparam logic [MAC_W-1:0]  DEST_MAC_RESET   = 48'hFFFF_FFFF_FFFF;
   localparam logic [MAC_W-1:0]  SRC_MAC_RESET    = 48'h0;
   localparam logic [TYPE_W-1:0] ETHER_TYPE_RESET = 16'h8FF0;

   // One queued payload byte, tagged by the front.
   typedef struct packed {
      logic [7:0] payload_byte;
      logic       is_last;
      logic       first;
   } efb_item_type;

   typedef struct packed {
      logic         valid;
      efb_item_type item;
   } efb_queue_type;

   typedef struct packed {
      logic [MAC_W-1:0]  dest_mac;
      logic [MAC_W-1:0]  src_mac;
      logic [TYPE_W-1:0] ether_type;
   } efb_cfg_type;

   // Fold one byte into the running CRC, least significant bit first.
   function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

endpackage

`default_nettype wire

>>> rtl/efb_csr.sv
`default_nettype none

module efb_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [efb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [efb_pkg::CSR_DATA_W-1:0]    csr_data,
   output efb_pkg::efb_cfg_type                   cfg
);
   import efb_pkg::*;

   efb_cfg_type cfg_ff;
   efb_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DEST_MAC:   cfg_in.dest_mac   = csr_data[MAC_W-1:0];
            CSR_SRC_MAC:    cfg_in.src_mac    = csr_data[MAC_W-1:0];
            CSR_ETHER_TYPE: cfg_in.ether_type = csr_data[TYPE_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_mac   <= DEST_MAC_RESET;
         cfg_ff.src_mac    <= SRC_MAC_RESET;
         cfg_ff.ether_type <= ETHER_TYPE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/efb_front.sv
`default_nettype none

module efb_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,
   input  wire logic              req_tlast,
   output efb_pkg::efb_queue_type head,
   input  wire logic              pop
);
   import efb_pkg::*;

   efb_item_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     first_ff, first_in;
   logic                     push;
   logic                     do_pop;
   efb_item_type             new_item;

   assign req_tready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid & req_tready;
   assign do_pop     = pop & (count_ff != '0);

   // A byte opens a frame when the byte before it closed one.
   assign new_item.payload_byte = req_tdata;
   assign new_item.is_last      = req_tlast;
   assign new_item.first        = first_ff;

   assign head.valid = (count_ff != '0);
   assign head.item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      first_in  = first_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
         first_in  = req_tlast;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         first_ff  <= 1'b1;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         first_ff  <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

>>> rtl/efb_back.sv
`default_nettype none

module efb_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire efb_pkg::efb_cfg_type  cfg,
   input  wire efb_pkg::efb_queue_type head,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [7:0]                 rsp_tdata,
   output logic                       rsp_tlast
);
   import efb_pkg::*;

   localparam logic [1:0] ST_PAY  = 2'd0;  // next queued byte, header first if it opens a frame
   localparam logic [1:0] ST_HDR  = 2'd1;  // rest of the header
   localparam logic [1:0] ST_BODY = 2'd2;  // payload byte that follows a header
   localparam logic [1:0] ST_FCS  = 2'd3;  // four check bytes

   localparam logic [CNT_W-1:0] HDR_LAST = CNT_W'(HDR_BYTES - 1);
   localparam logic [CNT_W-1:0] FCS_LAST = CNT_W'(FCS_BYTES - 1);

   logic [1:0]       st_ff, st_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]      crc_ff, crc_in;
   logic             valid_ff, valid_in;
   logic [7:0]       data_ff, data_in;
   logic             last_ff, last_in;

   logic             free;
   logic [CNT_W-1:0] hdr_idx;
   logic [8*HDR_BYTES-1:0] hdr_vec;
   logic [7:0]       hdr_byte;
   logic [31:0]      fcs;
   logic [7:0]       fcs_byte;
   logic             take_pay;

   assign free     = ~valid_ff | rsp_tready;
   assign hdr_vec  = {cfg.dest_mac, cfg.src_mac, cfg.ether_type};
   assign hdr_idx  = (st_ff == ST_HDR) ? cnt_ff : '0;
   assign hdr_byte = hdr_vec[8*(HDR_LAST - hdr_idx) +: 8];
   assign fcs      = ~crc_ff;
   assign fcs_byte = fcs[8*cnt_ff[1:0] +: 8];

   // Payload byte is popped from the queue and loaded into the output register in this cycle.
   assign take_pay = free & head.valid &
                     (((st_ff == ST_PAY) & ~head.item.first) | (st_ff == ST_BODY));

   always_comb begin
      st_in    = st_ff;
      cnt_in   = cnt_ff;
      crc_in   = crc_ff;
      valid_in = valid_ff & ~rsp_tready;
      data_in  = data_ff;
      last_in  = last_ff;
      pop      = take_pay;

      if (take_pay) begin
         valid_in = 1'b1;
         data_in  = head.item.payload_byte;
         last_in  = 1'b0;
         crc_in   = crc_fold(crc_ff, head.item.payload_byte);
         cnt_in   = '0;
         st_in    = head.item.is_last ? ST_FCS : ST_PAY;
      end else if (free) begin
         unique case (st_ff)
            ST_PAY: begin
               if (head.valid) begin
                  valid_in = 1'b1;
                  data_in  = hdr_byte;
                  last_in  = 1'b0;
                  crc_in   = crc_fold(CRC_INIT, hdr_byte);
                  cnt_in   = CNT_W'(1);
                  st_in    = ST_HDR;
               end
            end
            ST_HDR: begin
               valid_in = 1'b1;
               data_in  = hdr_byte;
               last_in  = 1'b0;
               crc_in   = crc_fold(crc_ff, hdr_byte);
               if (cnt_ff == HDR_LAST) begin
                  st_in = ST_BODY;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            ST_FCS: begin
               valid_in = 1'b1;
               data_in  = fcs_byte;
               last_in  = (cnt_ff == FCS_LAST);
               if (cnt_ff == FCS_LAST) begin
                  st_in  = ST_PAY;
                  cnt_in = '0;
                  crc_in = CRC_INIT;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            default: begin
               st_in = st_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_PAY;
         cnt_ff   <= '0;
         crc_ff   <= CRC_INIT;
         valid_ff <= 1'b0;
      end else begin
         st_ff    <= st_in;
         cnt_ff   <= cnt_in;
         crc_ff   <= crc_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

>>> rtl/ethernet_frame_fcs_builder.sv
`default_nettype none

// Ethernet frame builder. Payload bytes come in as requests on the req_ stream, one byte per
// request, with req_tlast set on the last byte of a frame. The first byte of each frame makes
// the block send the 14-byte header ahead of it: destination MAC and source MAC, each with
// bits 47:40 first, then the type field high byte first. Payload follows unchanged, and after
// the last payload byte the block appends the 4-byte IEEE 802.3 FCS (reflected CRC-32,
// polynomial 0xEDB88320, seeded with all ones, complemented, low byte first); rsp_tlast marks
// the final FCS byte. The output runs at one byte per clock whenever rsp_tready allows and,
// for payload, a queued byte is waiting. A sequencer feeds the single output byte register
// with header, payload or FCS bytes. A four-request queue sits in front of the sequencer, so
// requests keep flowing while the header or FCS goes out and while the output is stalled,
// until the queue fills. The header registers are written through the csr_ port (index 0
// destination MAC, 1 source MAC, 2 type; other indexes are ignored) and should only be
// written while no frame is in flight.

module ethernet_frame_fcs_builder (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Request stream.
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [7:0]                       req_tdata,   // [7:0] payload_byte
   input  wire logic                             req_tlast,   // is_last
   // Frame stream.
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [7:0]                            rsp_tdata,   // [7:0] frame_byte
   output logic                                  rsp_tlast,   // frame_end
   // Register writes.
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [efb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [efb_pkg::CSR_DATA_W-1:0]   csr_data
);
   import efb_pkg::*;

   efb_cfg_type   cfg;
   efb_queue_type head;
   logic          pop;

   // Header registers.
   efb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // The front queues each request and tags whether it opens a frame.
   efb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .head       (head),
      .pop        (pop)
   );

   // The back sends header, payload and FCS bytes and keeps the running CRC.
   efb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

>>> rtl/efb_checker.sv
`default_nettype none

module efb_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tlast
);

   // Output bytes since the last frame end, saturating.
   logic [4:0] beats_ff;
   logic [4:0] beats_in;
   logic       rsp_fire;

   assign rsp_fire = rsp_tvalid & rsp_tready;

   always_comb begin
      beats_in = beats_ff;
      if (rsp_fire) begin
         if (rsp_tlast) begin
            beats_in = '0;
         end else if (beats_ff != 5'd31) begin
            beats_in = beats_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beats_ff <= '0;
      end else begin
         beats_ff <= beats_in;
      end
   end

   // A stalled frame byte holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("frame byte changed while stalled");

   // Nothing is sent right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("frame byte valid after reset");

   // A frame holds header, at least one payload byte and FCS: nineteen bytes at least.
   assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_tlast |-> beats_ff >= 5'd18)
      else $error("frame ended too early");

   // The queue is empty after reset, so requests are taken at once.
   assert property (@(posedge clock) reset |=> req_tready)
      else $error("request not ready after reset");

endmodule

bind ethernet_frame_fcs_builder efb_checker u_efb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

>>> sim/ethernet_frame_fcs_builder_tb.sv
`default_nettype none

// Self-checking bench for the Ethernet frame builder.
//
// Payload requests are queued by the main initial block and fed to the req_ stream by a
// clocked driver. Every accepted request is run through a local model of the frame builder:
// it works out the header, the echoed payload byte and the FCS. The model keeps its own
// copy of the three header registers and of the running CRC. The frame bytes it predicts
// wait in a queue. A clocked monitor compares each byte taken from the rsp_ stream with the
// oldest prediction.
//
// All inputs change on the falling clock edge. Every handshake is sampled on the rising edge.

module ethernet_frame_fcs_builder_tb;

   import efb_pkg::*;

   // Index past the last register; the block must ignore writes to it.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   localparam int unsigned TARGET_REQUESTS = 220;
   // Cycles in a row without any handshake before the run is declared hung. The longest
   // legal quiet stretch is the forced receiver hold-off below, plus a long gap.
   localparam int unsigned WATCHDOG_LIMIT  = 1000;
   localparam int unsigned LONG_HOLD       = 150;
   // Cycles allowed after the last expected byte for stray output to show up.
   localparam int unsigned DRAIN_TAIL      = 12;
   localparam int unsigned MAX_REPORTS     = 40;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       is_last;
   } payload_req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } wire_byte_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = 8'h00;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [7:0]             rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_DEST_MAC;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   ethernet_frame_fcs_builder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Payload requests not yet offered, and frame bytes predicted but not yet seen.
   payload_req_type payload_queue[$];
   wire_byte_type   expected_wire[$];

   // Model copy of the header registers and of the frame state.
   logic [MAC_W-1:0]  hdr_dest_mac   = DEST_MAC_RESET;
   logic [MAC_W-1:0]  hdr_src_mac    = SRC_MAC_RESET;
   logic [TYPE_W-1:0] hdr_ether_type = ETHER_TYPE_RESET;
   logic              frame_open     = 1'b0;
   logic [31:0]       fcs_crc        = CRC_INIT;

   // Pacing controls, set by the main sequence and read by the driver and the receiver.
   bit          req_gaps_on      = 1'b1;
   bit          rsp_gaps_on      = 1'b1;
   bit          rsp_hold_request = 1'b0;
   bit          req_taken        = 1'b0;
   int unsigned req_gap_left     = 0;
   int unsigned rsp_stall_left   = 0;

   // Bookkeeping.
   int unsigned requests_queued   = 0;
   int unsigned requests_accepted = 0;
   int unsigned frames_built      = 0;
   int unsigned bytes_checked     = 0;
   int unsigned csr_writes        = 0;
   int unsigned phases_run        = 0;
   int unsigned mismatch_count    = 0;
   int unsigned quiet_cycles      = 0;

   // Idle stretches are mostly short, now and then much longer.
   function automatic int unsigned pick_idle_len();
      if ($urandom_range(0, 99) < 85)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Serial form of the reflected CRC-32: one input bit per shift, LSB first.
   function automatic logic [31:0] crc32_update(logic [31:0] crc, logic [7:0] octet);
      logic [31:0] acc;
      acc = crc;
      for (int b = 0; b < 8; b++) begin
         if (acc[0] ^ octet[b])
            acc = {1'b0, acc[31:1]} ^ CRC_POLY;
         else
            acc = {1'b0, acc[31:1]};
      end
      return acc;
   endfunction

   task automatic push_wire_byte(logic [7:0] octet, logic frame_end, bit fold);
      expected_wire.push_back('{frame_byte: octet, frame_end: frame_end});
      if (fold)
         fcs_crc = crc32_update(fcs_crc, octet);
   endtask

   // Frame bytes caused by one accepted payload request. The header is prepended when a new
   // frame opens, and the FCS is appended when the request closes the frame. The header and
   // the payload are folded into the CRC; the FCS bytes themselves are not.
   task automatic predict_frame_bytes(logic [7:0] payload_byte, logic is_last);
      logic [31:0] fcs;
      if (!frame_open) begin
         fcs_crc = CRC_INIT;
         for (int i = 5; i >= 0; i--)
            push_wire_byte(hdr_dest_mac[8*i +: 8], 1'b0, 1'b1);
         for (int i = 5; i >= 0; i--)
            push_wire_byte(hdr_src_mac[8*i +: 8], 1'b0, 1'b1);
         push_wire_byte(hdr_ether_type[15:8], 1'b0, 1'b1);
         push_wire_byte(hdr_ether_type[7:0], 1'b0, 1'b1);
         frame_open = 1'b1;
      end
      push_wire_byte(payload_byte, 1'b0, 1'b1);
      if (is_last) begin
         fcs = ~fcs_crc;
         for (int i = 0; i < 4; i++)
            push_wire_byte(fcs[8*i +: 8], (i == 3), 1'b0);
         frame_open = 1'b0;
         fcs_crc    = CRC_INIT;
         frames_built++;
      end
   endtask

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s: got %02h, expected %02h", $time, what, got, want);
   endtask

   // Rising edge: all handshakes are sampled here. A byte leaving the block is checked before
   // the request taken on the same edge is predicted, so a result cannot be matched against
   // a prediction from its own edge.
   always @(posedge clock) begin
      wire_byte_type want;
      bit            moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            bytes_checked++;
            if (expected_wire.size() == 0) begin
               report_mismatch("frame byte with nothing expected", rsp_tdata, 8'h00);
            end else begin
               want = expected_wire.pop_front();
               if (rsp_tdata !== want.frame_byte)
                  report_mismatch("frame_byte", rsp_tdata, want.frame_byte);
               if (rsp_tlast !== want.frame_end)
                  report_mismatch("frame_end", {7'b0, rsp_tlast}, {7'b0, want.frame_end});
            end
         end
         if (req_tvalid && req_tready) begin
            moved = 1'b1;
            req_taken = 1'b1;
            requests_accepted++;
            predict_frame_bytes(req_tdata, req_tlast);
         end
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            csr_writes++;
            case (csr_index)
               CSR_DEST_MAC:   hdr_dest_mac   = csr_data[MAC_W-1:0];
               CSR_SRC_MAC:    hdr_src_mac    = csr_data[MAC_W-1:0];
               CSR_ETHER_TYPE: hdr_ether_type = csr_data[TYPE_W-1:0];
               default: ;
            endcase
         end
         if (moved)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d frame bytes still expected",
                     $time, quiet_cycles, expected_wire.size());
            $display("Verification failed");
            $finish;
         end
      end
   end

   // Request driver. A request stays on the bus until it is taken. After that the next
   // request follows at once or after a random gap.
   always @(negedge clock) begin
      payload_req_type next_req;
      if (!reset && (!req_tvalid || req_taken)) begin
         if (req_gap_left != 0) begin
            req_gap_left--;
            req_tvalid <= 1'b0;
         end else if (payload_queue.size() != 0) begin
            next_req = payload_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_req.payload_byte;
            req_tlast  <= next_req.is_last;
            if (req_gaps_on && $urandom_range(0, 99) < 35)
               req_gap_left = pick_idle_len();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      req_taken = 1'b0;
   end

   // Frame receiver. It stalls at random, and for one long stretch when the main sequence
   // asks for it.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold_request) begin
         rsp_hold_request = 1'b0;
         rsp_stall_left   = LONG_HOLD - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_stall_left != 0) begin
         rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_gaps_on && $urandom_range(0, 99) < 20) begin
         rsp_stall_left = pick_idle_len() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic queue_payload(logic [7:0] payload_byte, logic is_last);
      payload_queue.push_back('{payload_byte: payload_byte, is_last: is_last});
      requests_queued++;
   endtask

   // Whole frames of random content; most are short, some run to a few dozen bytes.
   task automatic queue_random_frames(int unsigned count);
      int unsigned added;
      int unsigned len;
      added = 0;
      while (added < count) begin
         if ($urandom_range(0, 99) < 80)
            len = $urandom_range(1, 8);
         else
            len = $urandom_range(9, 40);
         for (int unsigned i = 0; i < len; i++)
            queue_payload(8'($urandom_range(0, 255)), (i == len - 1));
         added += len;
      end
   endtask

   // Hold the sender back until every predicted byte has come out. The extra cycles let any
   // stray byte surface before the next register write or the end of the run.
   task automatic wait_drained();
      do
         @(negedge clock);
      while (payload_queue.size() != 0 || requests_accepted != requests_queued ||
             expected_wire.size() != 0);
      repeat (DRAIN_TAIL) @(negedge clock);
      phases_run++;
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // New header settings for a random phase. The all-zero and all-one addresses come up
   // often. The type write carries junk above bit 15, which the block must drop.
   task automatic randomize_header();
      logic [63:0] r;
      int unsigned pick;
      r = {$urandom(), $urandom()};
      pick = $urandom_range(0, 3);
      write_csr(CSR_DEST_MAC, (pick == 0) ? '0 : (pick == 1) ? '1 : r[MAC_W-1:0]);
      r = {$urandom(), $urandom()};
      pick = $urandom_range(0, 3);
      write_csr(CSR_SRC_MAC, (pick == 0) ? '0 : (pick == 1) ? '1 : r[MAC_W-1:0]);
      r = {$urandom(), $urandom()};
      write_csr(CSR_ETHER_TYPE, r[CSR_DATA_W-1:0]);
      if ($urandom_range(0, 3) == 0)
         write_csr(CSR_UNUSED, r[CSR_DATA_W-1:0] ^ '1);
   endtask

   initial begin
      int unsigned phase;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset header values: one-byte frames at both byte extremes and a short frame.
      queue_payload(8'h00, 1'b1);
      queue_payload(8'hFF, 1'b1);
      queue_payload(8'h55, 1'b0);
      queue_payload(8'hAA, 1'b0);
      queue_payload(8'h0F, 1'b1);
      wait_drained();

      // Opposite address extremes, a type of zero sent with junk in the upper data bits, and
      // a write to the unused index, which must leave the header alone.
      write_csr(CSR_DEST_MAC, '0);
      write_csr(CSR_SRC_MAC, '1);
      write_csr(CSR_ETHER_TYPE, 48'hFFFF_FFFF_0000);
      write_csr(CSR_UNUSED, 48'h1234_5678_9ABC);
      queue_payload(8'h80, 1'b1);
      queue_payload(8'h01, 1'b0);
      queue_payload(8'hFE, 1'b0);
      queue_payload(8'h7F, 1'b0);
      queue_payload(8'h00, 1'b0);
      queue_payload(8'hFF, 1'b1);
      wait_drained();

      // Full type field and distinct bytes in each address position.
      write_csr(CSR_ETHER_TYPE, 48'h0000_0000_FFFF);
      write_csr(CSR_DEST_MAC, 48'h0102_0304_0506);
      write_csr(CSR_SRC_MAC, 48'hF0E1_D2C3_B4A5);
      queue_payload(8'hC3, 1'b1);
      queue_payload(8'h3C, 1'b0);
      queue_payload(8'h96, 1'b1);
      wait_drained();

      // Random phases, each with new header settings, until enough requests have gone in.
      // Phase 1 runs with no idling on either side. In phase 2 the receiver holds off for a
      // long stretch while the sender keeps offering requests back to back, so the internal
      // queue fills and req_tready must drop.
      phase = 0;
      while (requests_queued < TARGET_REQUESTS) begin
         randomize_header();
         req_gaps_on = (phase != 1 && phase != 2);
         rsp_gaps_on = (phase != 1);
         if (phase == 2)
            rsp_hold_request = 1'b1;
         queue_random_frames($urandom_range(20, 40));
         wait_drained();
         phase++;
      end
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;

      $display("Built %0d frames from %0d payload requests in %0d phases.",
               frames_built, requests_accepted, phases_run);
      $display("Checked %0d frame bytes after %0d register writes; %0d mismatches.",
               bytes_checked, csr_writes, mismatch_count);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
